// ===== src/vmw_pkg.sv =====
// Shared constants for the vertex model-to-world transform: register indexes,
// fixed field widths of the matrix, offset and normalization datapaths.
// No dependencies.
`default_nettype none

package vmw_pkg;

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_Z = 3'd5;

    // Matrix entries are signed Q2.14, three to a row register.
    localparam int MAT_W    = 16;
    localparam int MAT_FRAC = 14;
    localparam int OFF_W    = 32;

    // Identity matrix rows after reset.
    localparam logic [CFG_W-1:0] ROT_X_RST = 48'h0000_0000_4000;
    localparam logic [CFG_W-1:0] ROT_Y_RST = 48'h0000_4000_0000;
    localparam logic [CFG_W-1:0] ROT_Z_RST = 48'h4000_0000_0000;

    // Normalized magnitudes have their largest member in [2^29, 2^30).
    localparam int NRM_TOP = 29;
    localparam int NRM_W   = 30;
    localparam int SQ_W    = 2 * NRM_W;
    localparam int RAD_W   = 62;
    localparam int ROOT_W  = 31;

endpackage

`default_nettype wire

// ===== src/vmw_isqrt.sv =====
// Pipelined integer square root, one result bit per register stage.
// Depends on vmw_pkg for the radicand and root widths.
`default_nettype none

module vmw_isqrt
    import vmw_pkg::*;
#(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [RAD_W-1:0]  i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int STEPS = ROOT_W;

    logic [RAD_W-1:0]  r_rem  [STEPS];
    logic [RAD_W-1:0]  r_res  [STEPS];
    logic [SIDE_W-1:0] r_side [STEPS];
    logic [STEPS-1:0]  r_vld;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam logic [RAD_W-1:0] Bit = RAD_W'(1) << (2 * (STEPS - 1 - g));
        logic [RAD_W-1:0]  rem_in;
        logic [RAD_W-1:0]  res_in;
        logic [RAD_W-1:0]  trial;
        logic [SIDE_W-1:0] side_in;
        logic              vld_in;

        if (g == 0) begin : g_first
            assign rem_in  = i_rad;
            assign res_in  = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign res_in  = r_res[g-1];
            assign side_in = r_side[g-1];
            assign vld_in  = r_vld[g-1];
        end

        assign trial = res_in + Bit;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_in >= trial) begin
                    r_rem[g] <= rem_in - trial;
                    r_res[g] <= (res_in >> 1) + Bit;
                end else begin
                    r_rem[g] <= rem_in;
                    r_res[g] <= res_in >> 1;
                end
                r_side[g] <= side_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_root  = r_res[STEPS-1][ROOT_W-1:0];
    assign o_side  = r_side[STEPS-1];

endmodule

`default_nettype wire

// ===== src/vmw_ndiv.sv =====
// Pipelined restoring divider for three numerators over one shared divisor,
// one quotient bit per register stage. Depends on vmw_pkg for the divisor width.
`default_nettype none

module vmw_ndiv
    import vmw_pkg::*;
#(
    parameter int QBITS  = 15,
    parameter int NUM_W  = 45,
    parameter int SIDE_W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [2:0][NUM_W-1:0] i_num,
    input  logic [ROOT_W-1:0]     i_den,
    input  logic [SIDE_W-1:0]     i_side,
    output logic                  o_valid,
    output logic [2:0][QBITS-1:0] o_quo,
    output logic [SIDE_W-1:0]     o_side
);

    logic [2:0][NUM_W-1:0] r_rem  [QBITS];
    logic [2:0][QBITS-1:0] r_quo  [QBITS];
    logic [ROOT_W-1:0]     r_den  [QBITS];
    logic [SIDE_W-1:0]     r_side [QBITS];
    logic [QBITS-1:0]      r_vld;

    for (genvar g = 0; g < QBITS; g++) begin : g_step
        localparam int Sh = QBITS - 1 - g;
        logic [2:0][NUM_W-1:0] rem_in;
        logic [2:0][QBITS-1:0] quo_in;
        logic [ROOT_W-1:0]     den_in;
        logic [SIDE_W-1:0]     side_in;
        logic                  vld_in;
        logic [NUM_W-1:0]      dsh;

        if (g == 0) begin : g_first
            assign rem_in  = i_num;
            assign quo_in  = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign rem_in  = r_rem[g-1];
            assign quo_in  = r_quo[g-1];
            assign den_in  = r_den[g-1];
            assign side_in = r_side[g-1];
            assign vld_in  = r_vld[g-1];
        end

        assign dsh = NUM_W'(den_in) << Sh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    if (rem_in[k] >= dsh) begin
                        r_rem[g][k] <= rem_in[k] - dsh;
                        r_quo[g][k] <= quo_in[k] | (QBITS'(1) << Sh);
                    end else begin
                        r_rem[g][k] <= rem_in[k];
                        r_quo[g][k] <= quo_in[k];
                    end
                end
                r_den[g]  <= den_in;
                r_side[g] <= side_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end
    end

    assign o_valid = r_vld[QBITS-1];
    assign o_quo   = r_quo[QBITS-1];
    assign o_side  = r_side[QBITS-1];

endmodule

`default_nettype wire

// ===== src/vertex_model_to_world_transform.sv =====
// Top level of the vertex model-to-world transform: rotation, translation and
// normal renormalization. Depends on vmw_pkg, vmw_isqrt and vmw_ndiv.
//
// Usage: each transfer on the s_axis channel carries one vertex (position and
// normal). The block returns one transfer on the m_axis channel per vertex,
// in order: the position rotated by the 3x3 matrix, offset by the translation
// and saturated, and the rotated normal scaled to unit length (zero when the
// rotated normal has zero length). Matrix rows and offsets are written on the
// cfg channel, which is always ready; write it only while no vertex is in flight.
// Throughput is one vertex per clock unless a receiver stall fills the skid
// register. An input transfer reaches m_axis_tvalid through seven stages of
// products, sums, normalization and squares, 31 stages of the square root,
// one numerator stage, NORM_WIDTH - 1 divider stages and the output register.
// A synchronous low i_rst_n empties the pipeline and loads the identity matrix
// and zero offsets. When the receiver stalls, the result is held on m_axis and
// one more finished vertex is caught in the skid register; only then does
// s_axis_tready drop and the whole pipeline freeze.
`default_nettype none

module vertex_model_to_world_transform
    import vmw_pkg::*;
#(
    parameter int POS_WIDTH  = 32,
    parameter int NORM_WIDTH = 16,
    localparam int DATA_W    = ((3 * (POS_WIDTH + NORM_WIDTH) + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Vertex input.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // From bit 0: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, zero padding.
    input  logic [DATA_W-1:0]    s_axis_tdata,
    // Transformed vertex output.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // From bit 0: world_x, world_y, world_z, unit_nx, unit_ny, unit_nz, zero padding.
    output logic [DATA_W-1:0]    m_axis_tdata
);

    localparam int PW      = POS_WIDTH;
    localparam int NW      = NORM_WIDTH;
    localparam int NF      = NW - 2;
    localparam int PROD_W  = PW + MAT_W;
    localparam int PSUM_W  = PROD_W + 2;
    localparam int RND_W   = PSUM_W - MAT_FRAC;
    localparam int WS_W    = ((RND_W > OFF_W) ? RND_W : OFF_W) + 1;
    localparam int NPROD_W = NW + MAT_W;
    localparam int NSUM_W  = NPROD_W + 2;
    localparam int MAG_W   = NW + MAT_W;
    localparam int SH_W    = $clog2(MAG_W);
    localparam int WIDE_W  = MAG_W + NRM_TOP;
    localparam int QB      = NF + 1;
    localparam int NUM_W   = NRM_W + NF + 1;
    localparam int SQ_SIDE_W = 3 * PW + 4 + 3 * NRM_W;
    localparam int DV_SIDE_W = 3 * PW + 4;

    localparam logic signed [PSUM_W-1:0] RND_HALF = PSUM_W'(1) << (MAT_FRAC - 1);
    localparam logic signed [WS_W-1:0]   P_MAX    = WS_W'((64'(1) << (PW - 1)) - 64'(1));
    localparam logic signed [WS_W-1:0]   P_MIN    = -P_MAX - WS_W'(1);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [2:0][CFG_W-1:0] r_rot;
    logic [2:0][OFF_W-1:0] r_off;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= ROT_X_RST;
            r_rot[1] <= ROT_Y_RST;
            r_rot[2] <= ROT_Z_RST;
            r_off    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROT_X: r_rot[0] <= i_cfg_data;
                CFG_ROT_Y: r_rot[1] <= i_cfg_data;
                CFG_ROT_Z: r_rot[2] <= i_cfg_data;
                CFG_OFF_X: r_off[0] <= i_cfg_data[OFF_W-1:0];
                CFG_OFF_Y: r_off[1] <= i_cfg_data[OFF_W-1:0];
                CFG_OFF_Z: r_off[2] <= i_cfg_data[OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together unless the skid register is full.
    logic en;
    logic r_skid_vld;

    assign en            = !r_skid_vld;
    assign s_axis_tready = en;

    // ------------------------------------------------------------------
    // Stage 1: the eighteen products.
    // ------------------------------------------------------------------
    logic [2:0][PW-1:0]    w_pos;
    logic [2:0][NW-1:0]    w_nrm;
    logic [2:0][2:0][MAT_W-1:0] w_m;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pos[i] = s_axis_tdata[i*PW +: PW];
            w_nrm[i] = s_axis_tdata[3*PW + i*NW +: NW];
            for (int c = 0; c < 3; c++) begin
                w_m[i][c] = r_rot[i][c*MAT_W +: MAT_W];
            end
        end
    end

    logic [2:0][2:0][PROD_W-1:0]  r1_pp;
    logic [2:0][2:0][NPROD_W-1:0] r1_np;
    logic                         r1_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_pp[i][c] <= PROD_W'(signed'(w_m[i][c]) * signed'(w_pos[c]));
                    r1_np[i][c] <= NPROD_W'(signed'(w_m[i][c]) * signed'(w_nrm[c]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: row sums. The position sum carries the rounding half.
    // ------------------------------------------------------------------
    logic [2:0][PSUM_W-1:0] r2_ps;
    logic [2:0][NSUM_W-1:0] r2_ns;
    logic                   r2_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_ps[i] <= PSUM_W'(signed'(r1_pp[i][0])) + PSUM_W'(signed'(r1_pp[i][1]))
                          + PSUM_W'(signed'(r1_pp[i][2])) + RND_HALF;
                r2_ns[i] <= NSUM_W'(signed'(r1_np[i][0])) + NSUM_W'(signed'(r1_np[i][1]))
                          + NSUM_W'(signed'(r1_np[i][2]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: position rounding, translation and saturation; normal
    // magnitudes and signs.
    // ------------------------------------------------------------------
    logic signed [WS_W-1:0] w_ws  [3];
    logic [2:0][NSUM_W-1:0] w_abs;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ws[i]  = WS_W'(signed'(r2_ps[i][PSUM_W-1:MAT_FRAC]))
                     + WS_W'(signed'(r_off[i]));
            w_abs[i] = r2_ns[i][NSUM_W-1] ? (~r2_ns[i] + NSUM_W'(1)) : r2_ns[i];
        end
    end

    logic [2:0][PW-1:0]    r3_world;
    logic [2:0][MAG_W-1:0] r3_mag;
    logic [2:0]            r3_neg;
    logic                  r3_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_ws[i] > P_MAX) begin
                    r3_world[i] <= P_MAX[PW-1:0];
                end else if (w_ws[i] < P_MIN) begin
                    r3_world[i] <= P_MIN[PW-1:0];
                end else begin
                    r3_world[i] <= w_ws[i][PW-1:0];
                end
                r3_mag[i] <= w_abs[i][MAG_W-1:0];
                r3_neg[i] <= r2_ns[i][NSUM_W-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: position of the leading one of the largest magnitude, which
    // is the leading one of the OR of all three.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] w_or;
    logic [SH_W-1:0]  w_top;

    always_comb begin
        w_or  = r3_mag[0] | r3_mag[1] | r3_mag[2];
        w_top = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (w_or[b]) begin
                w_top = SH_W'(b);
            end
        end
    end

    logic [2:0][PW-1:0]    r4_world;
    logic [2:0][MAG_W-1:0] r4_mag;
    logic [2:0]            r4_neg;
    logic [SH_W-1:0]       r4_sh;
    logic                  r4_zero;
    logic                  r4_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_world <= r3_world;
            r4_mag   <= r3_mag;
            r4_neg   <= r3_neg;
            r4_sh    <= w_top;
            r4_zero  <= (w_or == '0);
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: shift all magnitudes so the largest has its top bit at 29.
    // Placing the magnitude 29 bits up and shifting right by the leading-one
    // position covers both the left and the right shift.
    // ------------------------------------------------------------------
    logic [2:0][WIDE_W-1:0] w_wide;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_wide[i] = {r4_mag[i], {NRM_TOP{1'b0}}} >> r4_sh;
        end
    end

    logic [2:0][PW-1:0]    r5_world;
    logic [2:0][NRM_W-1:0] r5_nm;
    logic [2:0]            r5_neg;
    logic                  r5_zero;
    logic                  r5_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_world <= r4_world;
            r5_neg   <= r4_neg;
            r5_zero  <= r4_zero;
            for (int i = 0; i < 3; i++) begin
                r5_nm[i] <= w_wide[i][NRM_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 6 and 7: squares, then their sum.
    // ------------------------------------------------------------------
    logic [2:0][PW-1:0]    r6_world;
    logic [2:0][NRM_W-1:0] r6_nm;
    logic [2:0][SQ_W-1:0]  r6_sq;
    logic [2:0]            r6_neg;
    logic                  r6_zero;
    logic                  r6_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_world <= r5_world;
            r6_nm    <= r5_nm;
            r6_neg   <= r5_neg;
            r6_zero  <= r5_zero;
            for (int i = 0; i < 3; i++) begin
                r6_sq[i] <= SQ_W'(r5_nm[i]) * SQ_W'(r5_nm[i]);
            end
        end
    end

    logic [2:0][PW-1:0]    r7_world;
    logic [2:0][NRM_W-1:0] r7_nm;
    logic [RAD_W-1:0]      r7_rad;
    logic [2:0]            r7_neg;
    logic                  r7_zero;
    logic                  r7_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_world <= r6_world;
            r7_nm    <= r6_nm;
            r7_neg   <= r6_neg;
            r7_zero  <= r6_zero;
            r7_rad   <= RAD_W'(r6_sq[0]) + RAD_W'(r6_sq[1]) + RAD_W'(r6_sq[2]);
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= s_axis_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    // ------------------------------------------------------------------
    // Length of the normalized normal.
    // ------------------------------------------------------------------
    logic                  sq_vld;
    logic [ROOT_W-1:0]     sq_root;
    logic [SQ_SIDE_W-1:0]  sq_side;
    logic [2:0][PW-1:0]    s_world;
    logic [2:0][NRM_W-1:0] s_nm;
    logic [2:0]            s_neg;
    logic                  s_zero;

    vmw_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_vld),
        .i_rad   (r7_rad),
        .i_side  ({r7_nm, r7_zero, r7_neg, r7_world}),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    assign {s_nm, s_zero, s_neg, s_world} = sq_side;

    // Numerators with half the length added, so the quotient rounds to nearest.
    logic [2:0][NUM_W-1:0] r8_num;
    logic [ROOT_W-1:0]     r8_den;
    logic [2:0][PW-1:0]    r8_world;
    logic [2:0]            r8_neg;
    logic                  r8_zero;
    logic                  r8_vld;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r8_num[i] <= (NUM_W'(s_nm[i]) << NF) + NUM_W'(sq_root >> 1);
            end
            r8_den   <= sq_root;
            r8_world <= s_world;
            r8_neg   <= s_neg;
            r8_zero  <= s_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld <= 1'b0;
        end else if (en) begin
            r8_vld <= sq_vld;
        end
    end

    // ------------------------------------------------------------------
    // Unit components: magnitude times 2^NF over the length.
    // ------------------------------------------------------------------
    logic                 dv_vld;
    logic [2:0][QB-1:0]   dv_quo;
    logic [DV_SIDE_W-1:0] dv_side;
    logic [2:0][PW-1:0]   d_world;
    logic [2:0]           d_neg;
    logic                 d_zero;

    vmw_ndiv #(
        .QBITS  (QB),
        .NUM_W  (NUM_W),
        .SIDE_W (DV_SIDE_W)
    ) u_ndiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r8_vld),
        .i_num   (r8_num),
        .i_den   (r8_den),
        .i_side  ({r8_zero, r8_neg, r8_world}),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    assign {d_zero, d_neg, d_world} = dv_side;

    // Apply the signs; a zero-length normal returns all zeros.
    logic [2:0][NW-1:0] w_unit;
    logic [DATA_W-1:0]  w_dout;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (d_zero) begin
                w_unit[i] = '0;
            end else if (d_neg[i]) begin
                w_unit[i] = NW'(0) - NW'(dv_quo[i]);
            end else begin
                w_unit[i] = NW'(dv_quo[i]);
            end
        end
        w_dout = DATA_W'({w_unit, d_world});
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry. The pipeline freezes only once
    // the skid entry is occupied, so a single stalled result does not stop
    // input transfers.
    // ------------------------------------------------------------------
    logic              r_out_vld;
    logic [DATA_W-1:0] r_out;
    logic [DATA_W-1:0] r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || m_axis_tready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= dv_vld;
            end
        end else if (dv_vld && en) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || m_axis_tready) begin
            r_out <= r_skid_vld ? r_skid : w_dout;
        end else if (en) begin
            r_skid <= w_dout;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

// ===== src/vmw_chk.sv =====
// Port-level checks for the vertex model-to-world transform, bound to the top
// level. Depends only on the top level's ports.
`default_nettype none

module vmw_chk #(
    parameter int DATA_W = 144
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata
);

    // Reset empties the output side and opens the input side.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output not empty after reset");

    // Input back-pressure only appears when a result is waiting.
    a_stall_has_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending result");

    // A full skid entry stays full while the receiver keeps stalling.
    a_skid_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && !s_axis_tready |=> !s_axis_tready)
        else $error("input reopened while output still stalled");

    // A stalled result holds.
    a_out_stable : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output changed");

endmodule

bind vertex_model_to_world_transform vmw_chk #(
    .DATA_W (DATA_W)
) u_vmw_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for vertex_model_to_world_transform: drives vertices
// on the input stream, predicts each transformed vertex and compares results.
// Depends on vmw_pkg and the RTL of the block.
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import vmw_pkg::*;

    localparam int POS_W  = 32;
    localparam int NORM_W = 16;
    localparam int DATA_W = ((3 * (POS_W + NORM_W) + 7) / 8) * 8;
    localparam int LATENCY = NORM_W + 39;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nx;
        logic signed [POS_W-1:0]  pz;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  px;
    } t_vertex;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // From bit 0: pos_x, pos_y, pos_z, norm_x, norm_y, norm_z.
    logic [DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // From bit 0: world_x, world_y, world_z, unit_nx, unit_ny, unit_nz.
    logic [DATA_W-1:0] m_axis_tdata;

    vertex_model_to_world_transform uut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow copy of the configuration registers.
    logic [CFG_W-1:0] mat_row [3];
    logic signed [OFF_W-1:0] world_off [3];

    t_vertex expected_vertices[$];
    int errors = 0;
    int vertices_sent = 0;
    int vertices_seen = 0;
    int idle_cycles = 0;
    bit hold_receiver = 1'b0;
    bit offering = 1'b0;
    int min_gap_mode = 0;

    function automatic logic signed [63:0] mat_at(int r, int c);
        return 64'(signed'(mat_row[r][16*c +: 16]));
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Rotate, translate and saturate the position; rotate and renormalize the normal.
    function automatic t_vertex transform_vertex(t_vertex v);
        t_vertex res;
        logic signed [63:0] p [3];
        logic signed [63:0] n [3];
        logic signed [63:0] acc;
        logic signed [63:0] rn;
        logic [63:0] mag [3];
        logic [63:0] top;
        logic [63:0] sq;
        logic [63:0] len;
        logic [63:0] q;
        logic neg [3];
        logic signed [POS_W-1:0] wp [3];
        logic signed [NORM_W-1:0] un [3];
        p[0] = v.px; p[1] = v.py; p[2] = v.pz;
        n[0] = v.nx; n[1] = v.ny; n[2] = v.nz;
        top = 0;
        for (int r = 0; r < 3; r++) begin
            // The exact sum fits in 64 bits, so rounding the sum equals the
            // split floor-and-remainder form.
            acc = 0;
            for (int c = 0; c < 3; c++) acc += mat_at(r, c) * p[c];
            acc = (acc + (64'sd1 <<< (MAT_FRAC - 1))) >>> MAT_FRAC;
            acc += 64'(world_off[r]);
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            wp[r] = acc[POS_W-1:0];
            rn = 0;
            for (int c = 0; c < 3; c++) rn += mat_at(r, c) * n[c];
            neg[r] = rn < 0;
            mag[r] = neg[r] ? -rn : rn;
            if (mag[r] > top) top = mag[r];
        end
        if (top == 0) begin
            for (int r = 0; r < 3; r++) un[r] = '0;
        end else begin
            while (top >= (64'd1 << 30)) begin
                top >>= 1;
                for (int r = 0; r < 3; r++) mag[r] >>= 1;
            end
            while (top < (64'd1 << 29)) begin
                top <<= 1;
                for (int r = 0; r < 3; r++) mag[r] <<= 1;
            end
            sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
            len = int_sqrt(sq);
            for (int r = 0; r < 3; r++) begin
                q = ((mag[r] << (NORM_W - 2)) + (len >> 1)) / len;
                if (neg[r]) q = -q;
                un[r] = q[NORM_W-1:0];
            end
        end
        res.px = wp[0]; res.py = wp[1]; res.pz = wp[2];
        res.nx = un[0]; res.ny = un[1]; res.nz = un[2];
        return res;
    endfunction

    // Random gap: mostly none or short, a few long.
    function automatic int pick_gap();
        int roll;
        if (min_gap_mode == 1) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Registers are written only while the pipeline is empty; the shadow
    // copy is updated at the same time, and indexes past five are dropped.
    // The channel's valid is lowered again after each write.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        i_cfg_index <= idx;
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ROT_X: mat_row[0] = value;
            CFG_ROT_Y: mat_row[1] = value;
            CFG_ROT_Z: mat_row[2] = value;
            CFG_OFF_X: world_off[0] = value[OFF_W-1:0];
            CFG_OFF_Y: world_off[1] = value[OFF_W-1:0];
            CFG_OFF_Z: world_off[2] = value[OFF_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Lower the input valid once, if an item is still being offered.
    task automatic stop_sending();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // Valid stays high from one item to the next when no gap is drawn.
    task automatic send_vertex(t_vertex v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            stop_sending();
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= DATA_W'(v);
        s_axis_tvalid <= 1'b1;
        offering = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_vertices.push_back(transform_vertex(v));
        vertices_sent++;
        @(negedge i_clk);
    endtask

    // Wait until every result is in, then let the pipeline drain fully.
    task automatic wait_idle();
        stop_sending();
        while (expected_vertices.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    function automatic t_vertex random_vertex(int style);
        t_vertex v;
        v = t_vertex'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        if (style == 1) begin
            // Moderate positions and unit-scale normals, typical mesh data.
            v.px = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            v.py = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            v.pz = $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            v.nx = $signed(16'($urandom_range(0, 32767))) - 16'sh4000;
            v.ny = $signed(16'($urandom_range(0, 32767))) - 16'sh4000;
            v.nz = $signed(16'($urandom_range(0, 32767))) - 16'sh4000;
        end else if (style == 2) begin
            v.nx = 16'($urandom_range(0, 2)) - 16'sd1;
            v.ny = 0;
            v.nz = 0;
        end
        return v;
    endfunction

    // Each result is compared with the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_vertex got;
        t_vertex want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_vertex'(m_axis_tdata[$bits(t_vertex)-1:0]);
            vertices_seen++;
            if (expected_vertices.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                want = expected_vertices.pop_front();
                if (got.px !== want.px) begin
                    errors++;
                    $display("%0t: world_x expected %h actual %h", $time, want.px, got.px);
                end
                if (got.py !== want.py) begin
                    errors++;
                    $display("%0t: world_y expected %h actual %h", $time, want.py, got.py);
                end
                if (got.pz !== want.pz) begin
                    errors++;
                    $display("%0t: world_z expected %h actual %h", $time, want.pz, got.pz);
                end
                if (got.nx !== want.nx) begin
                    errors++;
                    $display("%0t: unit_nx expected %h actual %h", $time, want.nx, got.nx);
                end
                if (got.ny !== want.ny) begin
                    errors++;
                    $display("%0t: unit_ny expected %h actual %h", $time, want.ny, got.ny);
                end
                if (got.nz !== want.nz) begin
                    errors++;
                    $display("%0t: unit_nz expected %h actual %h", $time, want.nz, got.nz);
                end
            end
        end
    end

    // Receiver ready: random stalls, or a long hold-off while the sender keeps going.
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                m_axis_tready <= 1'b0;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
        end
    end

    // Watchdog: too many cycles in a row with no transfer anywhere.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Extremes of all fields under the identity matrix, including overflow.
    task automatic test_field_extremes();
        t_vertex v;
        logic signed [POS_W-1:0] pe [4];
        logic signed [NORM_W-1:0] ne [4];
        pe[0] = 32'sh7FFF_FFFF; pe[1] = 32'sh8000_0000; pe[2] = 0; pe[3] = -1;
        ne[0] = 16'sh7FFF; ne[1] = 16'sh8000; ne[2] = 0; ne[3] = 16'sh4000;
        for (int k = 0; k < 4; k++) begin
            v.px = pe[k]; v.py = pe[(k + 1) % 4]; v.pz = pe[(k + 2) % 4];
            v.nx = ne[k]; v.ny = ne[(k + 1) % 4]; v.nz = ne[(k + 3) % 4];
            send_vertex(v);
        end
        // Zero-length normal.
        v = '0;
        v.px = 32'sh0001_0000;
        send_vertex(v);
        wait_idle();
        // Large offsets push the position into saturation both ways.
        write_register(CFG_OFF_X, 48'h0000_7FFF_FFFF);
        write_register(CFG_OFF_Y, 48'h0000_8000_0000);
        write_register(CFG_OFF_Z, 48'h0000_0000_0000);
        for (int k = 0; k < 4; k++) begin
            v.px = pe[k]; v.py = pe[k]; v.pz = pe[k];
            v.nx = 1; v.ny = -1; v.nz = 0;
            send_vertex(v);
        end
        wait_idle();
    endtask

    // Extreme matrices: most negative entries, a zero matrix, ignored index.
    task automatic test_matrix_extremes();
        t_vertex v;
        write_register(CFG_ROT_X, 48'h8000_8000_8000);
        write_register(CFG_ROT_Y, 48'h7FFF_7FFF_7FFF);
        write_register(CFG_ROT_Z, 48'h0000_0000_0000);
        write_register(3'd6, 48'hFFFF_FFFF_FFFF);
        write_register(3'd7, 48'h1234_5678_9ABC);
        write_register(CFG_OFF_X, 48'hFFFF_FFFF_FFFF);
        write_register(CFG_OFF_Y, 48'h0000_0001_0000);
        write_register(CFG_OFF_Z, 48'h0000_8000_0000);
        for (int k = 0; k < 8; k++) send_vertex(random_vertex(k % 3));
        v = '0;
        v.px = 32'sh8000_0000; v.py = 32'sh8000_0000; v.pz = 32'sh8000_0000;
        v.nx = 16'sh8000; v.ny = 16'sh8000; v.nz = 16'sh8000;
        send_vertex(v);
        wait_idle();
        // A zero matrix makes every normal zero-length.
        write_register(CFG_ROT_X, 48'h0);
        write_register(CFG_ROT_Y, 48'h0);
        send_vertex(random_vertex(0));
        wait_idle();
    endtask

    // Random configurations, each followed by a burst of random vertices.
    task automatic test_random_stream(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            for (int r = 0; r < 6; r++) begin
                write_register(CFG_IDX_W'(r), (ph % 3 == 0)
                    ? CFG_W'({$urandom, $urandom})
                    : {16'($urandom_range(0, 32767)) - 16'h4000,
                       16'($urandom_range(0, 32767)) - 16'h4000,
                       16'($urandom_range(0, 32767)) - 16'h4000});
            end
            min_gap_mode = (ph % 4 == 1);
            for (int k = 0; k < per_phase; k++)
                send_vertex(random_vertex($urandom_range(0, 9) < 6 ? 1
                                          : ($urandom_range(0, 9) < 8 ? 0 : 2)));
            min_gap_mode = 0;
            wait_idle();
        end
    endtask

    // The receiver holds off for a long stretch while vertices keep coming,
    // so the pipeline fills and the input stalls.
    task automatic test_back_pressure();
        fork
            begin
                hold_receiver = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_receiver = 1'b0;
            end
            begin
                min_gap_mode = 1;
                for (int k = 0; k < 120; k++) send_vertex(random_vertex(1));
                stop_sending();
                min_gap_mode = 0;
            end
        join
        wait_idle();
    endtask

    initial begin
        mat_row[0] = ROT_X_RST;
        mat_row[1] = ROT_Y_RST;
        mat_row[2] = ROT_Z_RST;
        for (int r = 0; r < 3; r++) world_off[r] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_field_extremes();
        test_matrix_extremes();
        test_back_pressure();
        test_random_stream(12, 120);
        wait_idle();
        $display("Sent %0d vertices, checked %0d results over extreme, zero and random",
                 vertices_sent, vertices_seen);
        $display("matrices and offsets, with random stalls and a long output hold-off.");
        if (errors == 0 && expected_vertices.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
